FILE: hdl/ctw_pkg.sv
// ----------------------------------------------------------------------------
// ctw_pkg: shared types and constants of the text console writer
// Field widths, item kinds, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package ctw_pkg;

   localparam int KIND_W      = 2;
   localparam int CHAR_W      = 8;
   localparam int COLOR_W     = 4;
   localparam int CELL_W      = 16;
   localparam int ROW_OUT_W   = 5;
   localparam int COL_OUT_W   = 7;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;

   localparam logic [CHAR_W-1:0]  BLANK_CHAR = 8'h20;
   localparam logic [COLOR_W-1:0] RESET_FG   = 4'd7;
   localparam logic [COLOR_W-1:0] RESET_BG   = 4'd0;
   localparam logic [CELL_W-1:0]  RESET_CELL = {RESET_BG, RESET_FG, BLANK_CHAR};

   localparam logic [CSR_INDEX_W-1:0] CSR_FOREGROUND = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACKGROUND = 2'd1;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUT   = 2'd0,
      KIND_CLEAR = 2'd1,
      KIND_READ  = 2'd2
   } kind_type;

   typedef enum logic [7:0] {
      ST_INIT  = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_ADDR  = 8'b0000_0100,
      ST_PUT   = 8'b0000_1000,
      ST_BLANK = 8'b0001_0000,
      ST_FILL  = 8'b0010_0000,
      ST_READ  = 8'b0100_0000,
      ST_EMIT  = 8'b1000_0000
   } state_type;

endpackage

FILE: hdl/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_writer_core: text-mode console cell store with cursor
// Put, clear and read items against a ROWS x COLUMNS cell memory.
// ----------------------------------------------------------------------------
// Steps: put goes address, put, emit to the result register, with a blanking pass
//   when the put scrolls (one bottom-row cell blanked per cycle); read goes address,
//   read, emit (address, emit if out of range or unused kind); clear fills every cell.
// Throughput: one item at a time, as requests are taken only in the idle state;
//   a new item is taken while the previous result waits in the output register.
// Reset: cursor, scroll offset and colours return to their reset values, then
//   a clearing pass writes every cell before req_tready.
// ----------------------------------------------------------------------------
module text_console_writer_core #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: char_code[7:0], read_row[12:8], read_column[19:13], zero pad
   input  logic [ctw_pkg::REQ_DATA_W-1:0]      req_tdata,
   // tuser: kind[1:0]
   input  logic [ctw_pkg::KIND_W-1:0]          req_tuser,
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: cell_word[15:0], cursor_row_out[20:16], cursor_column_out[27:21], zero pad
   output logic [ctw_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // configuration write port
   input  logic                                csr_we,
   input  logic [ctw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ctw_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int CELLS  = ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int ROW_W  = (ROWS > 2) ? $clog2(ROWS) : 1;
   localparam int COL_W  = $clog2(COLUMNS);

   localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
   localparam logic [ROW_W:0]    ROWS_WIDE = (ROW_W + 1)'(ROWS);

   // request field split
   logic [ctw_pkg::CHAR_W-1:0]    req_char;
   logic [ctw_pkg::ROW_OUT_W-1:0] req_row;
   logic [ctw_pkg::COL_OUT_W-1:0] req_col;

   assign req_char = req_tdata[7:0];
   assign req_row  = req_tdata[12:8];
   assign req_col  = req_tdata[19:13];

   // control state
   ctw_pkg::state_type          state_ff, state_in;
   logic [ROW_W-1:0]            cur_row_ff, cur_row_in;
   logic [COL_W-1:0]            cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]            top_ff, top_in;        // physical row of logical row 0
   logic [ADDR_W-1:0]           sweep_ff, sweep_in;
   logic [COL_W-1:0]            cnt_ff, cnt_in;
   logic [ctw_pkg::COLOR_W-1:0] fg_ff, fg_in;
   logic [ctw_pkg::COLOR_W-1:0] bg_ff, bg_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // item payload
   logic [ctw_pkg::KIND_W-1:0]    kind_ff, kind_in;
   logic [ctw_pkg::CHAR_W-1:0]    char_ff, char_in;
   logic                          rd_ok_ff, rd_ok_in;
   logic [ROW_W-1:0]              phys_row_ff, phys_row_in;
   logic [COL_W-1:0]              col_sel_ff, col_sel_in;
   logic [ADDR_W-1:0]             addr_ff, addr_in;
   logic [ADDR_W-1:0]             row_base_ff, row_base_in;
   logic [ctw_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // memory port
   logic                        ram_we;
   logic [ADDR_W-1:0]           ram_waddr;
   logic [ctw_pkg::CELL_W-1:0]  ram_wdata;
   logic                        ram_re;
   logic [ctw_pkg::CELL_W-1:0]  ram_rdata;

   // helpers
   logic                        req_xfer;
   logic                        rsp_free;
   logic [ROW_W-1:0]            row_pick;
   logic [ROW_W:0]              row_sum;
   logic [ctw_pkg::CELL_W-1:0]  blank_word;
   logic [ctw_pkg::CELL_W-1:0]  cell_out;

   assign req_tready = (state_ff == ctw_pkg::ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign blank_word = {bg_ff, fg_ff, ctw_pkg::BLANK_CHAR};

   // map the logical row onto the ring of physical rows
   assign row_pick = (req_tuser == ctw_pkg::KIND_PUT) ? cur_row_ff : ROW_W'(req_row);
   assign row_sum  = (ROW_W + 1)'(row_pick) + (ROW_W + 1)'(top_ff);

   assign cell_out = ((kind_ff == ctw_pkg::KIND_READ) && rd_ok_ff) ? ram_rdata
                                                                   : '0;

   always_comb begin
      state_in     = state_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      top_in       = top_ff;
      sweep_in     = sweep_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      char_in      = char_ff;
      rd_ok_in     = rd_ok_ff;
      phys_row_in  = phys_row_ff;
      col_sel_in   = col_sel_ff;
      addr_in      = addr_ff;
      row_base_in  = row_base_ff;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = sweep_ff;
      ram_wdata    = blank_word;
      ram_re       = 1'b0;

      // configuration: keep low nibble, drop unknown indexes
      fg_in = fg_ff;
      bg_in = bg_ff;
      if (csr_we) begin
         if (csr_index == ctw_pkg::CSR_FOREGROUND) begin
            fg_in = csr_wdata;
         end else if (csr_index == ctw_pkg::CSR_BACKGROUND) begin
            bg_in = csr_wdata;
         end
      end

      // drop the held result once it is taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ctw_pkg::ST_INIT: begin
            // reset clearing pass in the reset attribute
            ram_we    = 1'b1;
            ram_wdata = ctw_pkg::RESET_CELL;
            sweep_in  = sweep_ff + 1'b1;
            if (sweep_ff == LAST_CELL) begin
               sweep_in = '0;
               state_in = ctw_pkg::ST_IDLE;
            end
         end
         ctw_pkg::ST_IDLE: begin
            if (req_xfer) begin
               kind_in     = req_tuser;
               char_in     = req_char;
               rd_ok_in    = (32'(req_row) < ROWS) && (32'(req_col) < COLUMNS);
               phys_row_in = (row_sum >= ROWS_WIDE) ? ROW_W'(row_sum - ROWS_WIDE)
                                                    : ROW_W'(row_sum);
               col_sel_in  = (req_tuser == ctw_pkg::KIND_PUT) ? cur_col_ff
                                                             : COL_W'(req_col);
               sweep_in    = '0;
               state_in    = ctw_pkg::ST_ADDR;
            end
         end
         ctw_pkg::ST_ADDR: begin
            addr_in     = ADDR_W'(phys_row_ff * COLUMNS) + ADDR_W'(col_sel_ff);
            row_base_in = ADDR_W'(top_ff * COLUMNS);
            if (kind_ff == ctw_pkg::KIND_PUT) begin
               state_in = ctw_pkg::ST_PUT;
            end else if (kind_ff == ctw_pkg::KIND_CLEAR) begin
               state_in = ctw_pkg::ST_FILL;
            end else if ((kind_ff == ctw_pkg::KIND_READ) && rd_ok_ff) begin
               state_in = ctw_pkg::ST_READ;
            end else begin
               state_in = ctw_pkg::ST_EMIT;
            end
         end
         ctw_pkg::ST_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = addr_ff;
            ram_wdata = {bg_ff, fg_ff, char_ff};
            state_in  = ctw_pkg::ST_EMIT;
            if (cur_col_ff == LAST_COL) begin
               cur_col_in = '0;
               if (cur_row_ff == LAST_ROW) begin
                  // scroll: the old top row becomes the blank bottom row
                  top_in   = (top_ff == LAST_ROW) ? '0 : top_ff + 1'b1;
                  sweep_in = row_base_ff;
                  cnt_in   = '0;
                  state_in = ctw_pkg::ST_BLANK;
               end else begin
                  cur_row_in = cur_row_ff + 1'b1;
               end
            end else begin
               cur_col_in = cur_col_ff + 1'b1;
            end
         end
         ctw_pkg::ST_BLANK: begin
            ram_we   = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == LAST_COL) begin
               state_in = ctw_pkg::ST_EMIT;
            end
         end
         ctw_pkg::ST_FILL: begin
            ram_we   = 1'b1;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST_CELL) begin
               cur_row_in = '0;
               cur_col_in = '0;
               top_in     = '0;
               state_in   = ctw_pkg::ST_EMIT;
            end
         end
         ctw_pkg::ST_READ: begin
            ram_re   = 1'b1;
            state_in = ctw_pkg::ST_EMIT;
         end
         ctw_pkg::ST_EMIT: begin
            // hold until the output register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0000,
                               ctw_pkg::COL_OUT_W'(cur_col_ff),
                               ctw_pkg::ROW_OUT_W'(cur_row_ff),
                               cell_out};
               state_in     = ctw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ctw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ctw_pkg::ST_INIT;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         top_ff       <= '0;
         sweep_ff     <= '0;
         cnt_ff       <= '0;
         fg_ff        <= ctw_pkg::RESET_FG;
         bg_ff        <= ctw_pkg::RESET_BG;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         top_ff       <= top_in;
         sweep_ff     <= sweep_in;
         cnt_ff       <= cnt_in;
         fg_ff        <= fg_in;
         bg_ff        <= bg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      char_ff     <= char_in;
      rd_ok_ff    <= rd_ok_in;
      phys_row_ff <= phys_row_in;
      col_sel_ff  <= col_sel_in;
      addr_ff     <= addr_in;
      row_base_ff <= row_base_in;
      rsp_data_ff <= rsp_data_in;
   end

   ctw_cell_ram #(
      .DEPTH  (CELLS),
      .ADDR_W (ADDR_W)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // cursor and ring offset stay on the screen
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (32'(cur_col_ff) < COLUMNS) && (32'(cur_row_ff) < ROWS) && (32'(top_ff) < ROWS))
      else $error("cursor or scroll offset out of range");

   // no memory write while waiting for an item or for the output register
   a_quiet_ram: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ctw_pkg::ST_IDLE || state_ff == ctw_pkg::ST_EMIT) |-> !ram_we)
      else $error("memory written outside a work state");

   // a result appears only from the emit step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ctw_pkg::ST_EMIT))
      else $error("result raised outside the emit step");

   // the end of a clear sweep homes the cursor and the ring offset
   a_clear_home: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ctw_pkg::ST_FILL && sweep_ff == LAST_CELL)
      |=> (cur_row_ff == '0 && cur_col_ff == '0 && top_ff == '0))
      else $error("clear did not home the cursor");

endmodule

FILE: hdl/ctw_cell_ram.sv
// ----------------------------------------------------------------------------
// ctw_cell_ram: character cell memory
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module ctw_cell_ram #(
   parameter int DEPTH  = 1920,
   parameter int ADDR_W = 11
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [ADDR_W-1:0]            wr_addr,
   input  logic [ctw_pkg::CELL_W-1:0]   wr_data,
   input  logic                         rd_en,
   input  logic [ADDR_W-1:0]            rd_addr,
   output logic [ctw_pkg::CELL_W-1:0]   rd_data
);

   logic [ctw_pkg::CELL_W-1:0] mem [DEPTH];
   logic [ctw_pkg::CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
